[rtl/core/gbs_pkg.sv]
// Shared types and constants for the grid bilinear sampler.
`default_nettype none
package gbs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int FRAC_BITS  = 8;
  localparam int DATA_W     = 16;
  localparam int CFG_W      = 7;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CELL_W     = 3 * DATA_W;
  localparam int NUM_CH     = 3;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_AW    = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] CFG_RESET_COLS = CFG_W'(MAX_COLS);
  localparam logic [CFG_W-1:0] CFG_RESET_ROWS = CFG_W'(MAX_ROWS);
  localparam logic [CFG_W-1:0] CFG_MIN        = CFG_W'(2);

  // One queued operation: a cell write, or a sample resolved to cell and weights
  typedef struct packed {
    logic                  req_type;
    logic [COL_W-1:0]      col;
    logic [ROW_W-1:0]      row;
    logic [FRAC_BITS-1:0]  frac_x;
    logic [FRAC_BITS-1:0]  frac_y;
    logic [CELL_W-1:0]     data;
  } gbs_entry_t;

endpackage
`default_nettype wire

[rtl/core/gbs_queue.sv]
// Short FIFO between the front and back halves of the sampler.
`default_nettype none
module gbs_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire gbs_pkg::gbs_entry_t push_entry,
  input  wire logic               pop,
  output gbs_pkg::gbs_entry_t     head,
  output logic                    empty,
  output logic                    full
);
  import gbs_pkg::*;

  gbs_entry_t          slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;
  logic                do_push;
  logic                do_pop;

  assign empty   = (count == '0);
  assign full    = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

[rtl/core/gbs_front.sv]
// Front half: grid size registers, position clamp and split into cell and weight.
`default_nettype none
module gbs_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [gbs_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          req_type,
  input  wire logic [gbs_pkg::COL_W-1:0]     cell_col,
  input  wire logic [gbs_pkg::ROW_W-1:0]     cell_row,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_density,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_vel_x,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_vel_y,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] pos_x,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] pos_y,
  output gbs_pkg::gbs_entry_t                entry
);
  import gbs_pkg::*;

  localparam int PX_W = COL_W + FRAC_BITS;
  localparam int PY_W = ROW_W + FRAC_BITS;

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [CFG_W-1:0] cfg_sat;
  logic [PX_W-1:0]  px;
  logic [PY_W-1:0]  py;

  function automatic logic [CFG_W-1:0] sat_size(input logic [CFG_W-1:0] v,
                                                input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    r = v;
    if (r < CFG_MIN) r = CFG_MIN;
    if (r > hi) r = hi;
    return r;
  endfunction

  // Clamp a signed coordinate to [0, (size-1) << FRAC_BITS]
  function automatic logic [DATA_W-2:0] clamp_pos(input logic signed [DATA_W-1:0] p,
                                                  input logic [CFG_W-1:0] size);
    logic [DATA_W-2:0] hi;
    logic [DATA_W-2:0] r;
    hi = (DATA_W-1)'({size - 1'b1, {FRAC_BITS{1'b0}}});
    if (p[DATA_W-1]) r = '0;
    else if (p[DATA_W-2:0] > hi) r = hi;
    else r = p[DATA_W-2:0];
    return r;
  endfunction

  assign cfg_sat = sat_size(cfg_data, (cfg_index == CFG_IDX_WIDTH) ?
                            CFG_RESET_COLS : CFG_RESET_ROWS);

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= CFG_RESET_COLS;
      grid_height <= CFG_RESET_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_WIDTH:  grid_width  <= cfg_sat;
        CFG_IDX_HEIGHT: grid_height <= cfg_sat;
        default: ;
      endcase
    end
  end

  assign px = PX_W'(clamp_pos(pos_x, grid_width));
  assign py = PY_W'(clamp_pos(pos_y, grid_height));

  always_comb begin
    entry.req_type = req_type;
    entry.data     = {write_density, write_vel_x, write_vel_y};
    if (req_type == REQ_SAMPLE) begin
      entry.col    = px[PX_W-1:FRAC_BITS];
      entry.row    = py[PY_W-1:FRAC_BITS];
      entry.frac_x = px[FRAC_BITS-1:0];
      entry.frac_y = py[FRAC_BITS-1:0];
    end else begin
      entry.col    = cell_col;
      entry.row    = cell_row;
      entry.frac_x = '0;
      entry.frac_y = '0;
    end
  end

endmodule
`default_nettype wire

[rtl/core/gbs_back.sv]
// Back half: four parity banks of cells, then horizontal and vertical lerps.
`default_nettype none
module gbs_back (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire gbs_pkg::gbs_entry_t     head,
  input  wire logic                    head_valid,
  output logic                         pop,
  output logic                         done,
  output logic signed [gbs_pkg::DATA_W-1:0] sampled_density,
  output logic signed [gbs_pkg::DATA_W-1:0] sampled_vel_x,
  output logic signed [gbs_pkg::DATA_W-1:0] sampled_vel_y
);
  import gbs_pkg::*;

  localparam int LO_W = DATA_W + FRAC_BITS;
  localparam int V_W  = LO_W + FRAC_BITS;
  localparam int CH_W = COL_W - 1;
  localparam int RH_W = ROW_W - 1;

  logic                  rd_en;
  logic [NUM_BANKS-1:0]  wr_en;
  logic [BANK_AW-1:0]    wr_addr;
  logic [BANK_AW-1:0]    rd_addr [NUM_BANKS];
  logic [CELL_W-1:0]     rd_data [NUM_BANKS];
  logic [COL_W:0]        col_p1;
  logic [ROW_W:0]        row_p1;

  logic                  s1_valid;
  logic                  s1_xpar;
  logic                  s1_ypar;
  logic [FRAC_BITS-1:0]  s1_fx;
  logic [FRAC_BITS-1:0]  s1_fy;

  logic                  s2_valid;
  logic [FRAC_BITS-1:0]  s2_fy;
  logic [LO_W-1:0]       s2_lo [NUM_CH];
  logic [LO_W-1:0]       s2_up [NUM_CH];
  logic [LO_W-1:0]       lo_next [NUM_CH];
  logic [LO_W-1:0]       up_next [NUM_CH];
  logic [DATA_W-1:0]     res_next [NUM_CH];

  // Back end never stalls, so drain one entry per cycle
  assign pop   = head_valid;
  assign rd_en = head_valid && (head.req_type == REQ_SAMPLE);

  assign col_p1  = {1'b0, head.col} + 1'b1;
  assign row_p1  = {1'b0, head.row} + 1'b1;
  assign wr_addr = {head.row[ROW_W-1:1], head.col[COL_W-1:1]};

  // The neighbour past the last column or row may be any cell: its weight is zero,
  // so the lerps drop its value whenever the weight is zero
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      wr_en[b] = head_valid && (head.req_type == REQ_WRITE) &&
                 ({head.row[0], head.col[0]} == 2'(b));
      rd_addr[b] = {(head.row[0] == 1'(b >> 1)) ? head.row[ROW_W-1:1] : row_p1[RH_W:1],
                    (head.col[0] == 1'(b)) ? head.col[COL_W-1:1] : col_p1[CH_W:1]};
    end
  end

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [CELL_W-1:0] mem [BANK_DEPTH];
    logic [CELL_W-1:0] rd_q;

    always_ff @(posedge clk) begin
      if (wr_en[g]) mem[wr_addr] <= head.data;
      if (rd_en) rd_q <= mem[rd_addr[g]];
    end

    assign rd_data[g] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_xpar <= head.col[0];
      s1_ypar <= head.row[0];
      s1_fx   <= head.frac_x;
      s1_fy   <= head.frac_y;
    end
  end

  // Horizontal lerps in the biased domain: lo = a*ONE + (b - a)*fx
  always_comb begin
    logic [DATA_W-1:0]            ca;
    logic [DATA_W-1:0]            cb;
    logic [DATA_W-1:0]            cc;
    logic [DATA_W-1:0]            cd;
    logic signed [DATA_W:0]       dl;
    logic signed [DATA_W:0]       du;
    logic signed [LO_W+1:0]       sl;
    logic signed [LO_W+1:0]       su;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ca = rd_data[{s1_ypar, s1_xpar}][(NUM_CH-1-ch)*DATA_W +: DATA_W] ^
           {1'b1, {(DATA_W-1){1'b0}}};
      cb = rd_data[{s1_ypar, ~s1_xpar}][(NUM_CH-1-ch)*DATA_W +: DATA_W] ^
           {1'b1, {(DATA_W-1){1'b0}}};
      cc = rd_data[{~s1_ypar, s1_xpar}][(NUM_CH-1-ch)*DATA_W +: DATA_W] ^
           {1'b1, {(DATA_W-1){1'b0}}};
      cd = rd_data[{~s1_ypar, ~s1_xpar}][(NUM_CH-1-ch)*DATA_W +: DATA_W] ^
           {1'b1, {(DATA_W-1){1'b0}}};
      dl = (s1_fx == '0) ? '0 : $signed({1'b0, cb}) - $signed({1'b0, ca});
      du = (s1_fx == '0) ? '0 : $signed({1'b0, cd}) - $signed({1'b0, cc});
      sl = $signed({2'b00, ca, {FRAC_BITS{1'b0}}}) + dl * $signed({1'b0, s1_fx});
      su = $signed({2'b00, cc, {FRAC_BITS{1'b0}}}) + du * $signed({1'b0, s1_fx});
      lo_next[ch] = sl[LO_W-1:0];
      up_next[ch] = su[LO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_fy <= s1_fy;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s2_lo[ch] <= lo_next[ch];
        s2_up[ch] <= up_next[ch];
      end
    end
  end

  // Vertical lerp, then floor back to Q8.8 and drop the bias
  always_comb begin
    logic signed [LO_W:0]   dv;
    logic signed [V_W+1:0]  sv;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      dv = (s2_fy == '0) ? '0 : $signed({1'b0, s2_up[ch]}) - $signed({1'b0, s2_lo[ch]});
      sv = $signed({2'b00, s2_lo[ch], {FRAC_BITS{1'b0}}}) + dv * $signed({1'b0, s2_fy});
      res_next[ch] = sv[V_W-1 -: DATA_W] ^ {1'b1, {(DATA_W-1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      sampled_density <= res_next[0];
      sampled_vel_x   <= res_next[1];
      sampled_vel_y   <= res_next[2];
    end
  end

endmodule
`default_nettype wire

[rtl/core/grid_bilinear_sampler.sv]
// Top level of the grid bilinear sampler: front, queue and back.
// A sample accepted into the queue passes the bank read, the horizontal lerp register
// and the vertical lerp's output register, which shows its result with done high.
// Throughput: one item per cycle; the back drains the queue every cycle, so busy
// stays low in use. Writes give no result.
// Reset (rst, synchronous): clears the queue, the pipeline valids and done, and
// sets both grid sizes to 64. Cell contents are not cleared and read undefined
// until written. The receiver cannot stall.
`default_nettype none
module grid_bilinear_sampler (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [gbs_pkg::CFG_W-1:0]         cfg_data,
  input  wire logic                              req_type,
  input  wire logic [gbs_pkg::COL_W-1:0]         cell_col,
  input  wire logic [gbs_pkg::ROW_W-1:0]         cell_row,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_density,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_vel_x,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] write_vel_y,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] pos_x,
  input  wire logic signed [gbs_pkg::DATA_W-1:0] pos_y,
  output logic                                   done,
  output logic signed [gbs_pkg::DATA_W-1:0]      sampled_density,
  output logic signed [gbs_pkg::DATA_W-1:0]      sampled_vel_x,
  output logic signed [gbs_pkg::DATA_W-1:0]      sampled_vel_y
);
  import gbs_pkg::*;

  gbs_entry_t front_entry;
  gbs_entry_t head;
  logic       q_empty;
  logic       q_full;
  logic       q_pop;
  logic       accept;

  assign busy   = q_full;
  assign accept = start && !busy;

  gbs_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (req_type),
    .cell_col      (cell_col),
    .cell_row      (cell_row),
    .write_density (write_density),
    .write_vel_x   (write_vel_x),
    .write_vel_y   (write_vel_y),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .entry         (front_entry)
  );

  gbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  gbs_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head            (head),
    .head_valid      (!q_empty),
    .pop             (q_pop),
    .done            (done),
    .sampled_density (sampled_density),
    .sampled_vel_x   (sampled_vel_x),
    .sampled_vel_y   (sampled_vel_y)
  );

endmodule
`default_nettype wire

[rtl/core/gbs_checker.sv]
// Port-level checks on the sampler's transfer timing, bound to the top level.
`default_nettype none
module gbs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic req_type,
  input wire logic done
);
  import gbs_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_sample_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_SAMPLE) |-> ##4 done)
    else $error("sample transfer gave no result on time");

  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req_type == REQ_WRITE) |-> ##4 !done)
    else $error("write transfer gave a result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && req_type == REQ_SAMPLE, 4))
    else $error("result without a matching sample transfer");

endmodule

bind grid_bilinear_sampler gbs_checker u_gbs_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .req_type (req_type),
  .done     (done)
);
`default_nettype wire

[dv/tb_top.sv]
// Testbench for grid_bilinear_sampler: random and directed stimulus against an in-bench predictor.
`default_nettype none
module tb_top;
  import gbs_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int CELLS        = MAX_COLS * MAX_ROWS;
  localparam int ONE          = 1 << FRAC_BITS;

  typedef struct {
    logic                    req;
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [DATA_W-1:0] dens;
    logic signed [DATA_W-1:0] vx;
    logic signed [DATA_W-1:0] vy;
    logic signed [DATA_W-1:0] px;
    logic signed [DATA_W-1:0] py;
  } grid_req_t;

  typedef struct {
    logic [DATA_W-1:0] dens;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vy;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_IDX_WIDTH;
  logic [CFG_W-1:0] cfg_data = '0;
  logic req_type = REQ_WRITE;
  logic [COL_W-1:0] cell_col = '0;
  logic [ROW_W-1:0] cell_row = '0;
  logic signed [DATA_W-1:0] write_density = '0;
  logic signed [DATA_W-1:0] write_vel_x = '0;
  logic signed [DATA_W-1:0] write_vel_y = '0;
  logic signed [DATA_W-1:0] pos_x = '0;
  logic signed [DATA_W-1:0] pos_y = '0;
  logic done;
  logic signed [DATA_W-1:0] sampled_density;
  logic signed [DATA_W-1:0] sampled_vel_x;
  logic signed [DATA_W-1:0] sampled_vel_y;

  // predictor state
  logic [DATA_W-1:0] dens_mem [CELLS];
  logic [DATA_W-1:0] velx_mem [CELLS];
  logic [DATA_W-1:0] vely_mem [CELLS];
  int grid_cols = MAX_COLS;
  int grid_rows = MAX_ROWS;

  // stimulus bookkeeping
  bit        written_map [CELLS];
  grid_req_t pending_reqs [$];
  sample_t   expected_samples [$];
  grid_req_t drv_item;
  bit        taken = 1'b0;
  int        idle_pct = 0;
  int        mismatch_count = 0;
  int        cycle_count = 0;

  grid_bilinear_sampler DUT (
    .clk, .rst, .start, .busy, .cfg_we, .cfg_index, .cfg_data,
    .req_type, .cell_col, .cell_row, .write_density, .write_vel_x, .write_vel_y,
    .pos_x, .pos_y, .done, .sampled_density, .sampled_vel_x, .sampled_vel_y
  );

  always #5 clk = ~clk;

  function automatic int sat_size(logic [CFG_W-1:0] v, int hi);
    int s;
    s = v;
    if (s < 2) s = 2;
    if (s > hi) s = hi;
    return s;
  endfunction

  // Clamp a coordinate to the grid and split it into cell, neighbour and weight
  function automatic void split_coord(input logic signed [DATA_W-1:0] p, input int size,
                                      output int c0, output int c1, output int frac);
    int v;
    int hi;
    v = p;
    hi = (size - 1) * ONE;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    c0 = v >> FRAC_BITS;
    frac = v & (ONE - 1);
    c1 = (c0 + 1 < size) ? c0 + 1 : size - 1;
  endfunction

  // Blend in a biased unsigned domain so that the final shift floors
  function automatic logic [DATA_W-1:0] blend4(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                              logic [DATA_W-1:0] c, logic [DATA_W-1:0] d,
                                              int fx, int fy);
    longint unsigned ua, ub, uc, ud, lo, up, v;
    ua = a ^ 16'h8000;
    ub = b ^ 16'h8000;
    uc = c ^ 16'h8000;
    ud = d ^ 16'h8000;
    lo = ua * (ONE - fx) + ub * fx;
    up = uc * (ONE - fx) + ud * fx;
    v = (lo * (ONE - fy) + up * fy) >> (2 * FRAC_BITS);
    return DATA_W'(v - 64'd32768);
  endfunction

  function automatic void predict_req(grid_req_t r);
    int x0, x1, y0, y1, fx, fy, i00, i10, i01, i11;
    sample_t e;
    if (r.req == REQ_WRITE) begin
      i00 = int'(r.row) * MAX_COLS + int'(r.col);
      dens_mem[i00] = r.dens;
      velx_mem[i00] = r.vx;
      vely_mem[i00] = r.vy;
    end else begin
      split_coord(r.px, grid_cols, x0, x1, fx);
      split_coord(r.py, grid_rows, y0, y1, fy);
      i00 = y0 * MAX_COLS + x0;
      i10 = y0 * MAX_COLS + x1;
      i01 = y1 * MAX_COLS + x0;
      i11 = y1 * MAX_COLS + x1;
      e.dens = blend4(dens_mem[i00], dens_mem[i10], dens_mem[i01], dens_mem[i11], fx, fy);
      e.vx = blend4(velx_mem[i00], velx_mem[i10], velx_mem[i01], velx_mem[i11], fx, fy);
      e.vy = blend4(vely_mem[i00], vely_mem[i10], vely_mem[i01], vely_mem[i11], fx, fy);
      expected_samples.push_back(e);
    end
  endfunction

  function automatic logic [DATA_W-1:0] rand_q88();
    case ($urandom_range(0, 7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_coord(int size);
    int hi;
    hi = (size - 1) * ONE;
    case ($urandom_range(0, 5))
      0, 5: return DATA_W'($urandom_range(0, hi));
      1: return DATA_W'($urandom_range(0, size - 1) * ONE);
      2: return DATA_W'($urandom);
      3: return DATA_W'(hi + 150 - int'($urandom_range(0, 300)));
      default: return DATA_W'(-int'($urandom_range(1, 32768)));
    endcase
  endfunction

  task automatic queue_write(int col, int row, logic [DATA_W-1:0] d,
                             logic [DATA_W-1:0] vx, logic [DATA_W-1:0] vy);
    grid_req_t r;
    r.req = REQ_WRITE;
    r.col = COL_W'(col);
    r.row = ROW_W'(row);
    r.dens = d;
    r.vx = vx;
    r.vy = vy;
    r.px = DATA_W'($urandom);
    r.py = DATA_W'($urandom);
    pending_reqs.push_back(r);
    written_map[row * MAX_COLS + col] = 1'b1;
  endtask

  task automatic fill_cell(int col, int row);
    if (!written_map[row * MAX_COLS + col])
      queue_write(col, row, rand_q88(), rand_q88(), rand_q88());
  endtask

  // Load any neighbour not yet written, then queue the sample itself
  task automatic queue_sample(logic [DATA_W-1:0] px, logic [DATA_W-1:0] py);
    int x0, x1, y0, y1, fx, fy;
    grid_req_t r;
    split_coord(px, grid_cols, x0, x1, fx);
    split_coord(py, grid_rows, y0, y1, fy);
    fill_cell(x0, y0);
    fill_cell(x1, y0);
    fill_cell(x0, y1);
    fill_cell(x1, y1);
    r.req = REQ_SAMPLE;
    r.col = COL_W'($urandom);
    r.row = ROW_W'($urandom);
    r.dens = DATA_W'($urandom);
    r.vx = DATA_W'($urandom);
    r.vy = DATA_W'($urandom);
    r.px = px;
    r.py = py;
    pending_reqs.push_back(r);
  endtask

  task automatic write_cfg(logic idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_WIDTH) grid_cols = sat_size(val, MAX_COLS);
    else grid_rows = sat_size(val, MAX_ROWS);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || start || expected_samples.size() != 0)
      @(posedge clk);
    // writes give no result and may still be in the queue: let them land
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int n, int pct);
    idle_pct = pct;
    repeat (n) begin
      if ($urandom_range(0, 3) == 0)
        queue_write($urandom_range(0, MAX_COLS - 1), $urandom_range(0, MAX_ROWS - 1),
                    rand_q88(), rand_q88(), rand_q88());
      else
        queue_sample(pick_coord(grid_cols), pick_coord(grid_rows));
    end
    wait_drained();
  endtask

  // driver: change inputs on the falling edge, hold an item until its transfer
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        drv_item = pending_reqs.pop_front();
        start <= 1'b1;
        req_type <= drv_item.req;
        cell_col <= drv_item.col;
        cell_row <= drv_item.row;
        write_density <= drv_item.dens;
        write_vel_x <= drv_item.vx;
        write_vel_y <= drv_item.vy;
        pos_x <= drv_item.px;
        pos_y <= drv_item.py;
      end else begin
        start <= 1'b0;
      end
    end
    taken = 1'b0;
  end

  // monitor: check results and predict each transfer at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (done) begin
        if (expected_samples.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result with no sample outstanding: d=%h vx=%h vy=%h",
                     sampled_density, sampled_vel_x, sampled_vel_y);
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (sampled_density !== e.dens || sampled_vel_x !== e.vx ||
              sampled_vel_y !== e.vy) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("sample mismatch: expected d=%h vx=%h vy=%h, got d=%h vx=%h vy=%h",
                       e.dens, e.vx, e.vy, sampled_density, sampled_vel_x, sampled_vel_y);
          end
        end
      end
      if (start && !busy) begin
        predict_req(drv_item);
        taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // corner values on the first block of cells, then the grid edges
    queue_write(0, 0, 16'h7FFF, 16'h8000, 16'h0000);
    queue_write(1, 0, 16'h8000, 16'h7FFF, 16'hFFFF);
    queue_write(0, 1, 16'h0001, 16'hFFFF, 16'h7FFF);
    queue_write(1, 1, 16'hFFFF, 16'h0100, 16'h8000);
    queue_sample(16'h0000, 16'h0000);
    queue_sample(16'h8000, 16'h8000);
    queue_sample(16'h00FF, 16'h00FF);
    queue_sample(16'h0080, 16'h0040);
    queue_sample(16'hFFFF, 16'h0001);
    queue_write(0, 0, 16'h1234, 16'hEDCB, 16'h7FFF);
    queue_sample(16'h0010, 16'h0020);
    queue_write(62, 62, 16'h8000, 16'h7FFF, 16'h8000);
    queue_write(63, 62, 16'h7FFF, 16'h8000, 16'h7FFF);
    queue_write(62, 63, 16'h7FFF, 16'h7FFF, 16'h8000);
    queue_write(63, 63, 16'h8000, 16'h8000, 16'hFFFF);
    queue_sample(16'h7FFF, 16'h7FFF);
    queue_sample(16'h3F00, 16'h3F00);
    queue_sample(16'h3EFF, 16'h3EFF);
    queue_sample(16'h3F01, 16'h3E80);
    wait_drained();

    run_random(150, 0);
    write_cfg(CFG_IDX_WIDTH, 7'd2);
    write_cfg(CFG_IDX_HEIGHT, 7'd2);
    run_random(150, 85);
    write_cfg(CFG_IDX_WIDTH, 7'd127);
    write_cfg(CFG_IDX_HEIGHT, 7'd0);
    run_random(150, 23);
    write_cfg(CFG_IDX_WIDTH, 7'd1);
    write_cfg(CFG_IDX_HEIGHT, 7'd64);
    run_random(150, 0);
    write_cfg(CFG_IDX_WIDTH, 7'd65);
    write_cfg(CFG_IDX_HEIGHT, 7'd100);
    run_random(150, 85);
    write_cfg(CFG_IDX_WIDTH, CFG_W'($urandom_range(2, MAX_COLS)));
    write_cfg(CFG_IDX_HEIGHT, CFG_W'($urandom_range(2, MAX_ROWS)));
    run_random(150, 23);
    write_cfg(CFG_IDX_WIDTH, CFG_W'($urandom_range(2, 8)));
    write_cfg(CFG_IDX_HEIGHT, CFG_W'($urandom_range(2, 8)));
    run_random(150, 0);

    repeat (10) @(posedge clk);
    if (expected_samples.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire

[sim.f]
rtl/core/gbs_pkg.sv
rtl/core/gbs_queue.sv
rtl/core/gbs_front.sv
rtl/core/gbs_back.sv
rtl/core/grid_bilinear_sampler.sv
rtl/core/gbs_checker.sv
dv/tb_top.sv
